// ===== design/bpra_pkg.sv =====
// Package for the bitmap page-run allocator: sizes, widths, status codes.
// Used by the channel interfaces, the map RAM wrapper users and the top level.
// No dependencies.
package bpra_pkg;

    // Map geometry
    localparam int NUM_BLOCKS  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int NUM_WORDS   = NUM_BLOCKS / WORD_BITS;
    localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int WORD_CNT_W  = WORD_IDX_W + 1;

    // Bit groups examined per cycle inside a mixed map word
    localparam int GROUP_BITS  = 4;
    localparam int NUM_GROUPS  = WORD_BITS / GROUP_BITS;
    localparam int GRP_W       = $clog2(NUM_GROUPS);
    localparam int GRP_OFF_W   = $clog2(GROUP_BITS);

    // Field widths
    localparam int BLOCK_W     = 12;
    localparam int COUNT_W     = 13;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_SPACE    = 2'd1,
        ST_BAD_REQUEST = 2'd2
    } status_t;

endpackage

// ===== design/bpra_if.sv =====
// Channel interfaces of the bitmap page-run allocator: request, response, config.
// Depends on bpra_pkg.

// Request channel: one beat per allocate or free request
interface bpra_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [bpra_pkg::BLOCK_W-1:0] start_block;
    logic [bpra_pkg::COUNT_W-1:0] block_count;

    modport source (output valid, output req_type, output start_block,
                    output block_count, input ready);
    modport sink   (input valid, input req_type, input start_block,
                    input block_count, output ready);
endinterface

// Response channel: one beat per request
interface bpra_resp_if;
    logic                        valid;
    logic                        ready;
    bpra_pkg::status_t           status;
    logic [bpra_pkg::BLOCK_W-1:0] run_start;

    modport source (output valid, output status, output run_start, input ready);
    modport sink   (input valid, input status, input run_start, output ready);
endinterface

// Configuration write channel: total block count
interface bpra_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bpra_pkg::COUNT_W-1:0] total_blocks;

    modport source (output valid, output total_blocks, input ready);
    modport sink   (input valid, input total_blocks, output ready);
endinterface

// ===== design/bpra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/bitmap_page_run_allocator.sv =====
// First-fit bitmap page-run allocator, top level.
// Depends on bpra_pkg, the interfaces in bpra_if.sv and bpra_ram.
//
// Channels: req (sink) takes allocate/free requests, resp (source) returns one
// beat per request, cfg (sink) writes total_blocks and is always ready. Write
// cfg only while no request is in flight.
// The occupancy map is 4096 bits held as 128 words of 32 bits in one RAM with a
// single read and a single write port. A row-valid flop per word makes unwritten
// words read as all used, so reset takes effect at once with no clearing pass.
// Allocate: the scan reads one map word per cycle while words are wholly free or
// wholly used; a mixed word, or the word that holds the block total, is stepped
// 4 bits a cycle. The run is then marked with a read-modify-write (S_MARK_RD,
// S_MARK_WR) of each word it touches.
// Free: a read-modify-write of each word touched. A zero count answers bad_request.
// req is ready only when the sequencer is idle. The result sits in an output
// register; a stalled receiver holds it and the next request is still accepted,
// but that request cannot finish until the earlier result has been taken.
// Reset marks every block used, sets total_blocks to 4096 and empties the output.
module bitmap_page_run_allocator (
    input  logic            clk,
    input  logic            rst_n,
    bpra_cfg_if.sink        cfg,
    bpra_req_if.sink        req,
    bpra_resp_if.source     resp
);

    localparam logic [bpra_pkg::WORD_BITS-1:0] ALL_ONES = '1;
    localparam logic [bpra_pkg::WORD_BITS-1:0] ALL_ZERO = '0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EX,
        S_BITS,
        S_MARK_RD,
        S_MARK_WR,
        S_DONE
    } state_t;

    state_t                                  state_reg, state_next;
    logic [bpra_pkg::COUNT_W-1:0]            total_reg, total_next;
    logic                                    set_reg, set_next;
    logic [bpra_pkg::COUNT_W-1:0]            count_reg, count_next;
    logic [bpra_pkg::WORD_CNT_W-1:0]         word_reg, word_next;
    logic [bpra_pkg::COUNT_W-1:0]            run_reg, run_next;
    logic [bpra_pkg::WORD_BITS-1:0]          data_reg, data_next;
    logic [bpra_pkg::GRP_W-1:0]              grp_reg, grp_next;
    logic [bpra_pkg::BLOCK_W-1:0]            lo_reg, lo_next;
    logic [bpra_pkg::BLOCK_W-1:0]            hi_reg, hi_next;
    logic [bpra_pkg::BLOCK_W-1:0]            found_reg, found_next;
    bpra_pkg::status_t                       status_reg, status_next;
    logic                                    out_valid_reg, out_valid_next;
    bpra_pkg::status_t                       out_status_reg, out_status_next;
    logic [bpra_pkg::BLOCK_W-1:0]            out_start_reg, out_start_next;
    logic [bpra_pkg::NUM_WORDS-1:0]          row_valid_reg, row_valid_next;
    logic                                    rv_q_reg, rv_q_next;

    // Map RAM ports
    logic                                    ram_wr_en;
    logic [bpra_pkg::WORD_IDX_W-1:0]         ram_wr_addr;
    logic [bpra_pkg::WORD_BITS-1:0]          ram_wr_data;
    logic                                    ram_rd_en;
    logic [bpra_pkg::WORD_IDX_W-1:0]         ram_rd_addr;
    logic [bpra_pkg::WORD_BITS-1:0]          ram_rd_data;

    // Derived values
    logic [bpra_pkg::COUNT_W-1:0]            limit;
    logic [bpra_pkg::WORD_BITS-1:0]          rd_word;
    logic [bpra_pkg::COUNT_W-1:0]            base;
    logic [bpra_pkg::COUNT_W:0]              base_end;
    logic                                    full_word;

    bpra_ram #(
        .WIDTH (bpra_pkg::WORD_BITS),
        .DEPTH (bpra_pkg::NUM_WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Effective total, map word as read, and the current word's block range
    assign limit     = (total_reg > bpra_pkg::COUNT_W'(bpra_pkg::NUM_BLOCKS))
                       ? bpra_pkg::COUNT_W'(bpra_pkg::NUM_BLOCKS) : total_reg;
    assign rd_word   = rv_q_reg ? ram_rd_data : ALL_ONES;
    assign base      = {word_reg, {bpra_pkg::BIT_IDX_W{1'b0}}};
    assign base_end  = {1'b0, base} + (bpra_pkg::COUNT_W+1)'(bpra_pkg::WORD_BITS);
    assign full_word = base_end <= {1'b0, limit};

    assign cfg.ready      = 1'b1;
    assign req.ready      = (state_reg == S_IDLE);
    assign resp.valid     = out_valid_reg;
    assign resp.status    = out_status_reg;
    assign resp.run_start = out_start_reg;

    // Sequencer
    always_comb
    begin
        logic [bpra_pkg::COUNT_W:0]           req_end;
        logic [bpra_pkg::COUNT_W-1:0]         end_clip;
        logic [bpra_pkg::COUNT_W-1:0]         r;
        logic                                 h;
        logic                                 past;
        logic [bpra_pkg::COUNT_W-1:0]         idx;
        logic [bpra_pkg::BLOCK_W-1:0]         hidx;
        logic [bpra_pkg::BIT_IDX_W-1:0]       pos;
        logic [bpra_pkg::COUNT_W-1:0]         fnd;
        logic [bpra_pkg::COUNT_W-1:0]         run_sum;
        logic [bpra_pkg::BIT_IDX_W-1:0]       lo_off;
        logic [bpra_pkg::BIT_IDX_W-1:0]       hi_off;
        logic [bpra_pkg::WORD_BITS-1:0]       mask;
        logic [bpra_pkg::WORD_CNT_W-1:0]      word_inc;
        logic [bpra_pkg::COUNT_W:0]           next_base;

        state_next      = state_reg;
        total_next      = total_reg;
        set_next        = set_reg;
        count_next      = count_reg;
        word_next       = word_reg;
        run_next        = run_reg;
        data_next       = data_reg;
        grp_next        = grp_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        row_valid_next  = row_valid_reg;
        rv_q_next       = rv_q_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = word_reg[bpra_pkg::WORD_IDX_W-1:0];
        ram_wr_data = ALL_ZERO;
        ram_rd_en   = 1'b0;
        ram_rd_addr = word_reg[bpra_pkg::WORD_IDX_W-1:0];

        req_end  = '0;
        end_clip = '0;
        r        = run_reg;
        h        = 1'b0;
        past     = 1'b0;
        idx      = '0;
        hidx     = '0;
        pos      = '0;
        fnd      = '0;
        run_sum  = run_reg + bpra_pkg::COUNT_W'(bpra_pkg::WORD_BITS);
        lo_off   = '0;
        hi_off   = '1;
        mask     = '0;
        word_inc = word_reg + 1'b1;
        next_base = base_end;

        // Configuration beat
        if (cfg.valid)
        begin
            total_next = cfg.total_blocks;
        end

        // Response beat taken
        if (out_valid_reg && resp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    count_next = req.block_count;
                    found_next = '0;
                    run_next   = '0;
                    if (req.block_count == '0)
                    begin
                        status_next = bpra_pkg::ST_BAD_REQUEST;
                        state_next  = S_DONE;
                    end
                    else if (req.req_type == bpra_pkg::REQ_ALLOC)
                    begin
                        set_next  = 1'b1;
                        word_next = '0;
                        if (limit == '0)
                        begin
                            status_next = bpra_pkg::ST_NO_SPACE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        // Free: clip the run to the effective total
                        set_next    = 1'b0;
                        status_next = bpra_pkg::ST_OK;
                        req_end     = {2'b00, req.start_block}
                                      + {1'b0, req.block_count};
                        end_clip    = (req_end > {1'b0, limit})
                                      ? limit : req_end[bpra_pkg::COUNT_W-1:0];
                        if ({1'b0, req.start_block} >= limit)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            lo_next    = req.start_block;
                            hi_next    = bpra_pkg::BLOCK_W'(end_clip - 1'b1);
                            word_next  = {1'b0, req.start_block[bpra_pkg::BLOCK_W-1:
                                                                bpra_pkg::BIT_IDX_W]};
                            state_next = S_MARK_RD;
                        end
                    end
                end
            end

            S_SCAN_RD:
            begin
                ram_rd_en  = 1'b1;
                rv_q_next  = row_valid_reg[ram_rd_addr];
                state_next = S_SCAN_EX;
            end

            S_SCAN_EX:
            begin
                if (full_word && (rd_word == ALL_ZERO) && (run_sum >= count_reg))
                begin
                    // Run completes inside a wholly free word
                    fnd        = base - run_reg;
                    found_next = fnd[bpra_pkg::BLOCK_W-1:0];
                    lo_next    = fnd[bpra_pkg::BLOCK_W-1:0];
                    hi_next    = bpra_pkg::BLOCK_W'(fnd + count_reg - 1'b1);
                    word_next  = {1'b0, fnd[bpra_pkg::BLOCK_W-1:bpra_pkg::BIT_IDX_W]};
                    state_next = S_MARK_RD;
                end
                else if (full_word && (rd_word == ALL_ZERO || rd_word == ALL_ONES))
                begin
                    // Uniform word: extend or break the run, fetch the next word
                    run_next  = (rd_word == ALL_ZERO) ? run_sum : '0;
                    word_next = word_inc;
                    if (next_base >= {1'b0, limit})
                    begin
                        status_next = bpra_pkg::ST_NO_SPACE;
                        found_next  = '0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = word_inc[bpra_pkg::WORD_IDX_W-1:0];
                        rv_q_next   = row_valid_reg[ram_rd_addr];
                    end
                end
                else
                begin
                    data_next  = rd_word;
                    grp_next   = '0;
                    state_next = S_BITS;
                end
            end

            S_BITS:
            begin
                // Step one group of bits in order
                for (int j = 0; j < bpra_pkg::GROUP_BITS; j++)
                begin
                    pos = {grp_reg, bpra_pkg::GRP_OFF_W'(j)};
                    idx = base + bpra_pkg::COUNT_W'(pos);
                    if (!h && !past)
                    begin
                        if (idx >= limit)
                        begin
                            past = 1'b1;
                        end
                        else if (!data_reg[pos])
                        begin
                            r = r + 1'b1;
                            if (r == count_reg)
                            begin
                                h    = 1'b1;
                                hidx = idx[bpra_pkg::BLOCK_W-1:0];
                            end
                        end
                        else
                        begin
                            r = '0;
                        end
                    end
                end
                run_next = r;
                if (h)
                begin
                    fnd        = {1'b0, hidx} + 1'b1 - count_reg;
                    found_next = fnd[bpra_pkg::BLOCK_W-1:0];
                    lo_next    = fnd[bpra_pkg::BLOCK_W-1:0];
                    hi_next    = hidx;
                    word_next  = {1'b0, fnd[bpra_pkg::BLOCK_W-1:bpra_pkg::BIT_IDX_W]};
                    state_next = S_MARK_RD;
                end
                else if (past)
                begin
                    status_next = bpra_pkg::ST_NO_SPACE;
                    found_next  = '0;
                    state_next  = S_DONE;
                end
                else if (grp_reg == bpra_pkg::GRP_W'(bpra_pkg::NUM_GROUPS - 1))
                begin
                    word_next = word_inc;
                    if (next_base >= {1'b0, limit})
                    begin
                        status_next = bpra_pkg::ST_NO_SPACE;
                        found_next  = '0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    grp_next = grp_reg + 1'b1;
                end
            end

            S_MARK_RD:
            begin
                ram_rd_en  = 1'b1;
                rv_q_next  = row_valid_reg[ram_rd_addr];
                state_next = S_MARK_WR;
            end

            S_MARK_WR:
            begin
                // Set or clear the run's bits in this word
                if (word_reg[bpra_pkg::WORD_IDX_W-1:0]
                    == lo_reg[bpra_pkg::BLOCK_W-1:bpra_pkg::BIT_IDX_W])
                begin
                    lo_off = lo_reg[bpra_pkg::BIT_IDX_W-1:0];
                end
                if (word_reg[bpra_pkg::WORD_IDX_W-1:0]
                    == hi_reg[bpra_pkg::BLOCK_W-1:bpra_pkg::BIT_IDX_W])
                begin
                    hi_off = hi_reg[bpra_pkg::BIT_IDX_W-1:0];
                end
                mask        = (ALL_ONES << lo_off) & (ALL_ONES >> (~hi_off));
                ram_wr_en   = 1'b1;
                ram_wr_data = set_reg ? (rd_word | mask) : (rd_word & ~mask);
                row_valid_next[ram_wr_addr] = 1'b1;
                if (word_reg[bpra_pkg::WORD_IDX_W-1:0]
                    == hi_reg[bpra_pkg::BLOCK_W-1:bpra_pkg::BIT_IDX_W])
                begin
                    status_next = bpra_pkg::ST_OK;
                    state_next  = S_DONE;
                end
                else
                begin
                    word_next  = word_inc;
                    state_next = S_MARK_RD;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || resp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_start_next  = found_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_reg      <= bpra_pkg::COUNT_W'(bpra_pkg::NUM_BLOCKS);
            set_reg        <= 1'b0;
            count_reg      <= '0;
            word_reg       <= '0;
            run_reg        <= '0;
            data_reg       <= '0;
            grp_reg        <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            found_reg      <= '0;
            status_reg     <= bpra_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_status_reg <= bpra_pkg::ST_OK;
            out_start_reg  <= '0;
            row_valid_reg  <= '0;
            rv_q_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            set_reg        <= set_next;
            count_reg      <= count_next;
            word_reg       <= word_next;
            run_reg        <= run_next;
            data_reg       <= data_next;
            grp_reg        <= grp_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            found_reg      <= found_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_start_reg  <= out_start_next;
            row_valid_reg  <= row_valid_next;
            rv_q_reg       <= rv_q_next;
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_page_run_allocator: mixes allocate and free
// requests under random handshake stalls and checks each response against a predictor.
// Depends on bpra_pkg, the channel interfaces in bpra_if.sv and the allocator RTL.

module tb;

    localparam int END_SETTLE = 64;   // cycles allowed for stray responses
    localparam int HOLD_LEN   = 500;  // long receiver hold-off

    // Expected response of one request
    typedef struct packed {
        bpra_pkg::status_t                status;
        logic [bpra_pkg::BLOCK_W-1:0]     run_start;
    } alloc_result_t;

    // Occupancy map predictor and store of expected responses
    class alloc_scoreboard;
        bit                               used_map[bpra_pkg::NUM_BLOCKS];
        logic [bpra_pkg::COUNT_W-1:0]     total_reg;
        alloc_result_t                    expected_q[$];
        int                               mismatches;
        int                               requests;
        int                               n_ok;
        int                               n_no_space;
        int                               n_bad;

        function new();
            foreach (used_map[i])
                used_map[i] = 1'b1;
            total_reg  = bpra_pkg::COUNT_W'(bpra_pkg::NUM_BLOCKS);
            mismatches = 0;
            requests   = 0;
            n_ok       = 0;
            n_no_space = 0;
            n_bad      = 0;
        endfunction

        function void set_total(logic [bpra_pkg::COUNT_W-1:0] value);
            total_reg = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("[%0t] ERROR: %s", $realtime, msg);
            mismatches++;
        endtask

        // First-fit search / run clear on the predicted map
        function alloc_result_t predict(logic kind, logic [bpra_pkg::BLOCK_W-1:0] start,
                                        logic [bpra_pkg::COUNT_W-1:0] count);
            alloc_result_t res;
            int limit;
            int run;
            int found;
            bit hit;
            limit         = (total_reg > bpra_pkg::NUM_BLOCKS)
                            ? bpra_pkg::NUM_BLOCKS : int'(total_reg);
            res.status    = bpra_pkg::ST_OK;
            res.run_start = '0;
            found         = 0;
            hit           = 1'b0;
            run           = 0;
            if (count == 0)
            begin
                res.status = bpra_pkg::ST_BAD_REQUEST;
            end
            else if (kind == bpra_pkg::REQ_ALLOC)
            begin
                for (int i = 0; i < limit && !hit; i++)
                begin
                    if (!used_map[i])
                    begin
                        run++;
                        if (run == int'(count))
                        begin
                            found = i + 1 - int'(count);
                            hit   = 1'b1;
                        end
                    end
                    else
                    begin
                        run = 0;
                    end
                end
                if (hit)
                begin
                    for (int i = found; i < found + int'(count); i++)
                        used_map[i] = 1'b1;
                    res.run_start = found[bpra_pkg::BLOCK_W-1:0];
                end
                else
                begin
                    res.status = bpra_pkg::ST_NO_SPACE;
                end
            end
            else
            begin
                // blocks at or past the total are left alone
                for (int i = 0; i < int'(count); i++)
                begin
                    if (int'(start) + i >= limit)
                        break;
                    used_map[int'(start) + i] = 1'b0;
                end
            end
            return res;
        endfunction

        function alloc_result_t note_request(logic kind,
                                             logic [bpra_pkg::BLOCK_W-1:0] start,
                                             logic [bpra_pkg::COUNT_W-1:0] count);
            alloc_result_t res;
            res = predict(kind, start, count);
            expected_q.push_back(res);
            requests++;
            return res;
        endfunction

        task check_result(bpra_pkg::status_t status,
                          logic [bpra_pkg::BLOCK_W-1:0] run_start);
            alloc_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                report($sformatf("response beat with nothing outstanding (status %0d start %0d)",
                                 status, run_start));
                return;
            end
            exp_res = expected_q.pop_front();
            case (exp_res.status)
                bpra_pkg::ST_OK:       n_ok++;
                bpra_pkg::ST_NO_SPACE: n_no_space++;
                default:               n_bad++;
            endcase
            if (status !== exp_res.status)
                report($sformatf("status got %0d expected %0d", status, exp_res.status));
            if (run_start !== exp_res.run_start)
                report($sformatf("run_start got %0d expected %0d", run_start,
                                 exp_res.run_start));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    bpra_req_if  req_ch();
    bpra_resp_if resp_ch();
    bpra_cfg_if  cfg_ch();

    alloc_scoreboard sb = new();

    int send_idle_pct = 27;
    int recv_idle_pct = 85;
    int recv_hold     = 0;

    // runs handed out and not yet returned, as predicted
    int live_first[$];
    int live_len[$];

    bitmap_page_run_allocator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .resp  (resp_ch)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            resp_ch.ready <= 1'b0;
            recv_hold = recv_hold - 1;
        end
        else
        begin
            resp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Response monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && resp_ch.valid === 1'b1 && resp_ch.ready === 1'b1)
            sb.check_result(resp_ch.status, resp_ch.run_start);
    end

    // Watchdog
    initial
    begin
        #100_000_000;
        $display("Timeout with %0d responses outstanding", sb.pending());
        $display("Regression FAIL");
        $finish;
    end

    // One request beat; returns at the accepting rising edge
    task automatic issue_request(logic kind, logic [bpra_pkg::BLOCK_W-1:0] start,
                                 logic [bpra_pkg::COUNT_W-1:0] count);
        alloc_result_t res;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.start_block <= start;
        req_ch.block_count <= count;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        res = sb.note_request(kind, start, count);
        if (kind == bpra_pkg::REQ_ALLOC && res.status == bpra_pkg::ST_OK)
        begin
            live_first.push_back(int'(res.run_start));
            live_len.push_back(int'(count));
        end
    endtask

    // Drop valid and wait until every response is back
    task automatic wait_results_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Register write; only called with the block idle
    task automatic write_block_total(logic [bpra_pkg::COUNT_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.total_blocks <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.set_total(value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly allocate / free-back traffic, with stray frees and zero counts
    task automatic random_requests(int n);
        int pick;
        int r;
        int idx;
        logic [bpra_pkg::COUNT_W-1:0] cnt;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick >= 45 && pick < 80 && live_first.size() == 0)
                pick = 0;
            if (pick < 45)
            begin
                r = $urandom_range(99);
                if (r < 70)
                    cnt = bpra_pkg::COUNT_W'($urandom_range(16, 1));
                else if (r < 92)
                    cnt = bpra_pkg::COUNT_W'($urandom_range(256, 17));
                else if (r < 98)
                    cnt = bpra_pkg::COUNT_W'($urandom_range(2048, 257));
                else
                    cnt = bpra_pkg::COUNT_W'($urandom_range(8191, 2049));
                issue_request(bpra_pkg::REQ_ALLOC,
                              bpra_pkg::BLOCK_W'($urandom_range(4095)), cnt);
            end
            else if (pick < 80)
            begin
                // give back a run that was handed out
                idx = $urandom_range(live_first.size() - 1);
                issue_request(bpra_pkg::REQ_FREE, bpra_pkg::BLOCK_W'(live_first[idx]),
                              bpra_pkg::COUNT_W'(live_len[idx]));
                live_first.delete(idx);
                live_len.delete(idx);
            end
            else if (pick < 88)
            begin
                if ($urandom_range(9) == 0)
                    cnt = bpra_pkg::COUNT_W'($urandom_range(8191, 1));
                else
                    cnt = bpra_pkg::COUNT_W'($urandom_range(64, 1));
                issue_request(bpra_pkg::REQ_FREE,
                              bpra_pkg::BLOCK_W'($urandom_range(4095)), cnt);
            end
            else if (pick < 93)
            begin
                issue_request(($urandom_range(1) != 0) ? bpra_pkg::REQ_FREE
                                                        : bpra_pkg::REQ_ALLOC,
                              bpra_pkg::BLOCK_W'($urandom_range(4095)), '0);
            end
            else
            begin
                issue_request(bpra_pkg::REQ_FREE, bpra_pkg::BLOCK_W'($urandom_range(4095)),
                              bpra_pkg::COUNT_W'($urandom_range(4096, 256)));
            end
        end
    endtask

    // One random phase: set the total, release the managed range, then traffic
    task automatic run_phase(int send_pct, int recv_pct,
                             logic [bpra_pkg::COUNT_W-1:0] total, int n, bit with_hold);
        int saved_pct;
        wait_results_drained();
        write_block_total(total);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        live_first.delete();
        live_len.delete();
        issue_request(bpra_pkg::REQ_FREE, '0, total);
        random_requests(n / 2);
        if (with_hold)
        begin
            // long receiver stall while the sender keeps pushing
            saved_pct = send_idle_pct;
            send_idle_pct = 0;
            @(negedge clk);
            req_ch.valid <= 1'b0;
            @(posedge clk);
            recv_hold = HOLD_LEN;
            for (int k = 0; k < 6; k++)
                issue_request(bpra_pkg::REQ_ALLOC, bpra_pkg::BLOCK_W'($urandom_range(4095)),
                              bpra_pkg::COUNT_W'($urandom_range(8, 1)));
            send_idle_pct = saved_pct;
            wait_results_drained();
        end
        random_requests(n - n / 2);
    endtask

    // Main sequence
    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = bpra_pkg::REQ_ALLOC;
        req_ch.start_block  = '0;
        req_ch.block_count  = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.total_blocks = '0;
        resp_ch.ready       = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset map is fully used, zero counts, full-map and oversize runs
        issue_request(bpra_pkg::REQ_ALLOC, '0, 13'd1);
        issue_request(bpra_pkg::REQ_ALLOC, '0, '0);
        issue_request(bpra_pkg::REQ_FREE, 12'd4095, '0);
        issue_request(bpra_pkg::REQ_FREE, '0, 13'd4096);
        issue_request(bpra_pkg::REQ_ALLOC, 12'd4095, 13'd4096);
        issue_request(bpra_pkg::REQ_FREE, 12'd4000, 13'd8191);
        issue_request(bpra_pkg::REQ_ALLOC, '0, 13'd97);
        issue_request(bpra_pkg::REQ_ALLOC, '0, 13'd96);
        issue_request(bpra_pkg::REQ_FREE, '0, 13'd4096);
        issue_request(bpra_pkg::REQ_FREE, '0, 13'd4096);
        issue_request(bpra_pkg::REQ_ALLOC, '0, 13'd8191);
        issue_request(bpra_pkg::REQ_ALLOC, '0, 13'd4097);
        issue_request(bpra_pkg::REQ_ALLOC, '0, 13'd1);
        issue_request(bpra_pkg::REQ_ALLOC, '0, 13'd2);
        issue_request(bpra_pkg::REQ_FREE, 12'd1, 13'd1);
        issue_request(bpra_pkg::REQ_ALLOC, '0, 13'd3);
        issue_request(bpra_pkg::REQ_ALLOC, '0, 13'd1);

        // Directed: empty total, single block, small total
        wait_results_drained();
        write_block_total('0);
        issue_request(bpra_pkg::REQ_ALLOC, '0, 13'd1);
        issue_request(bpra_pkg::REQ_FREE, '0, 13'd5);
        wait_results_drained();
        write_block_total(13'd1);
        issue_request(bpra_pkg::REQ_FREE, '0, 13'd1);
        issue_request(bpra_pkg::REQ_ALLOC, '0, 13'd1);
        issue_request(bpra_pkg::REQ_ALLOC, '0, 13'd1);
        wait_results_drained();
        write_block_total(13'd40);
        issue_request(bpra_pkg::REQ_FREE, '0, 13'd8191);
        issue_request(bpra_pkg::REQ_ALLOC, '0, 13'd40);
        issue_request(bpra_pkg::REQ_FREE, 12'd39, 13'd1);
        issue_request(bpra_pkg::REQ_ALLOC, '0, 13'd1);

        // Random phases: sender/receiver stall mixes and block totals
        run_phase(27, 85, 13'd4096, 140, 1'b1);
        run_phase(85, 27, 13'd8191, 140, 1'b0);
        run_phase(0, 0, bpra_pkg::COUNT_W'($urandom_range(4096, 64)), 140, 1'b0);

        wait_results_drained();
        repeat (END_SETTLE) @(negedge clk);

        $display("Covered %0d requests: %0d ok, %0d no_space, %0d bad_request responses",
                 sb.requests, sb.n_ok, sb.n_no_space, sb.n_bad);
        $display("Totals from 0 to 8191, a %0d-cycle response hold-off, %0d mismatches",
                 HOLD_LEN, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
